// File: rtl/clock_set_display_controller_core_defines.svh
// assertion macros for the clock set display controller
// used by files that include this header; needs clk and rst in scope
`ifndef CLOCK_SET_DISPLAY_CONTROLLER_CORE_DEFINES_SVH
`define CLOCK_SET_DISPLAY_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication
`define CSDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("csdc assertion failed");

// next-cycle implication
`define CSDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("csdc assertion failed");

`endif

// File: rtl/csdc_pkg.sv
// shared codes, segment patterns, display struct and glyph lookup
// no dependencies
package csdc_pkg;

  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_SEC    = 3'd1;
  localparam logic [2:0] KIND_MIN_HR = 3'd2;
  localparam logic [2:0] KIND_NEXT   = 3'd3;
  localparam logic [2:0] KIND_EDIT   = 3'd4;

  localparam logic [2:0] MODE_SEC   = 3'd1;
  localparam logic [2:0] MODE_TIME  = 3'd2;
  localparam logic [2:0] MODE_WORDA = 3'd3;
  localparam logic [2:0] MODE_WORDC = 3'd4;

  localparam logic [2:0] DIGIT_NONE = 3'd0;
  localparam logic [2:0] DIGIT_MIN_LO = 3'd1;
  localparam logic [2:0] DIGIT_MIN_HI = 3'd2;
  localparam logic [2:0] DIGIT_HR_LO  = 3'd3;
  localparam logic [2:0] DIGIT_HR_HI  = 3'd4;

  localparam logic [2:0] REG_NONE = 3'd0;
  localparam logic [2:0] REG_MIN  = 3'd1;
  localparam logic [2:0] REG_HR   = 3'd2;

  localparam logic [7:0] LOCKOUT_RESET = 8'd128;

  localparam logic [7:0] SEG_DASH  = 8'hFD;
  localparam logic [7:0] SEG_CHR_X = 8'h91;
  localparam logic [7:0] SEG_CHR_E = 8'h61;
  localparam logic [7:0] SEG_CHR_L = 8'hE3;
  localparam logic [7:0] SEG_CHR_A = 8'h11;
  localparam logic [7:0] SEG_CHR_C = 8'h63;
  localparam logic [7:0] SEG_ZERO  = 8'h03;
  localparam logic [7:0] SEG_DP_MASK = 8'hFE;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] edit_digit;
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hr;
  } disp_t;

  function automatic logic [7:0] glyph(input logic [3:0] nib);
    logic [7:0] g;
    case (nib)
      4'd0: g = SEG_ZERO;
      4'd1: g = 8'h9F;
      4'd2: g = 8'h25;
      4'd3: g = 8'h0D;
      4'd4: g = 8'h99;
      4'd5: g = 8'h49;
      4'd6: g = 8'h41;
      4'd7: g = 8'h1F;
      4'd8: g = 8'h01;
      4'd9: g = 8'h09;
      default: g = SEG_DASH;
    endcase
    return g;
  endfunction

endpackage

// File: rtl/clock_set_display_controller_core.sv
// front panel of a four-digit bcd clock: button handling, lockout, set writes
// depends on csdc_pkg, csdc_seg_encode and the defines header
// a word accepted on s_* is registered in the input stage and then in the result stage before it appears on m_*
// throughput: one word per cycle while m_* is not stalled, set by the single-pass logic between the two stages
// both stages advance together; a stalled m_* side holds the result and backs up s_tready
// reset (rst, synchronous): mode 1, no edit digit, time cleared, no lockout, lockout_ticks 128
`include "clock_set_display_controller_core_defines.svh"

module clock_set_display_controller_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,    // lockout_ticks
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,     // seconds_byte, minutes_byte, hours_byte
  input  logic [2:0]  s_tuser,     // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,     // seg_pos0..seg_pos3, write_reg, write_value, zero pad
  output logic [0:0]  m_tuser      // write_valid
);

  logic        in_valid;
  logic [2:0]  in_kind;
  logic [7:0]  in_sec;
  logic [7:0]  in_min;
  logic [7:0]  in_hr;
  logic        advance;

  logic [7:0]  lockout_ticks;
  logic [2:0]  display_mode;
  logic [2:0]  display_mode_next;
  logic [2:0]  edit_digit;
  logic [2:0]  edit_digit_next;
  logic [7:0]  seconds_value;
  logic [7:0]  seconds_value_next;
  logic [7:0]  minutes_value;
  logic [7:0]  minutes_value_next;
  logic [7:0]  hours_value;
  logic [7:0]  hours_value_next;
  logic        lockout_active;
  logic        lockout_active_next;
  logic [7:0]  lockout_count;
  logic [7:0]  lockout_count_next;
  logic [7:0]  count_inc;

  logic        wv_next;
  logic [2:0]  wreg_next;
  logic [7:0]  wval_next;
  logic [7:0]  bump;

  csdc_pkg::disp_t disp_next;
  logic [3:0][7:0] seg_next;

  logic        out_valid;
  logic [3:0][7:0] out_seg;
  logic        out_wv;
  logic [2:0]  out_wreg;
  logic [7:0]  out_wval;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;

  // digit increment with bcd wrap
  always_comb begin
    case (edit_digit)
      csdc_pkg::DIGIT_MIN_LO:
        bump = (minutes_value[3:0] < 4'd9) ? minutes_value + 8'h01 : minutes_value & 8'hF0;
      csdc_pkg::DIGIT_MIN_HI:
        bump = (minutes_value[7:4] < 4'd5) ? minutes_value + 8'h10 : minutes_value & 8'h0F;
      csdc_pkg::DIGIT_HR_LO: begin
        if (hours_value[3:0] < 4'd3) bump = hours_value + 8'h01;
        else if (hours_value[7:4] == 4'd2) bump = hours_value & 8'hF0;
        else if (hours_value[3:0] < 4'd9) bump = hours_value + 8'h01;
        else bump = hours_value & 8'hF0;
      end
      default: begin
        if (hours_value[7:4] < 4'd1) bump = hours_value + 8'h10;
        else if (hours_value[3:0] > 4'd3) bump = hours_value & 8'h0F;
        else if (hours_value[7:4] < 4'd2) bump = hours_value + 8'h10;
        else bump = hours_value & 8'h0F;
      end
    endcase
  end

  always_comb begin
    display_mode_next   = display_mode;
    edit_digit_next     = edit_digit;
    seconds_value_next  = seconds_value;
    minutes_value_next  = minutes_value;
    hours_value_next    = hours_value;
    lockout_active_next = lockout_active;
    lockout_count_next  = lockout_count;
    wv_next   = 1'b0;
    wreg_next = csdc_pkg::REG_NONE;
    wval_next = 8'h00;
    count_inc = lockout_count + 8'd1;
    case (in_kind)
      csdc_pkg::KIND_TICK: begin
        if (lockout_active) begin
          if (count_inc == lockout_ticks) begin
            lockout_count_next  = 8'd0;
            lockout_active_next = 1'b0;
          end else begin
            lockout_count_next = count_inc;
          end
        end
      end
      csdc_pkg::KIND_SEC: seconds_value_next = in_sec;
      csdc_pkg::KIND_MIN_HR: begin
        minutes_value_next = in_min;
        hours_value_next   = in_hr;
      end
      csdc_pkg::KIND_NEXT: begin
        if (!lockout_active) begin
          if (edit_digit == csdc_pkg::DIGIT_NONE) begin
            display_mode_next = (display_mode inside {[csdc_pkg::MODE_SEC:csdc_pkg::MODE_WORDA]})
                                ? display_mode + 3'd1 : csdc_pkg::MODE_SEC;
          end else if (display_mode == csdc_pkg::MODE_TIME &&
                       edit_digit <= csdc_pkg::DIGIT_HR_HI) begin
            wv_next   = 1'b1;
            wreg_next = (edit_digit <= csdc_pkg::DIGIT_MIN_HI) ? csdc_pkg::REG_MIN
                                                                : csdc_pkg::REG_HR;
            wval_next = bump;
          end
          lockout_active_next = 1'b1;
          lockout_count_next  = 8'd0;
        end
      end
      csdc_pkg::KIND_EDIT: begin
        if (!lockout_active) begin
          if (display_mode == csdc_pkg::MODE_TIME) begin
            edit_digit_next = (edit_digit >= csdc_pkg::DIGIT_HR_HI) ? csdc_pkg::DIGIT_NONE
                                                                     : edit_digit + 3'd1;
          end
          lockout_active_next = 1'b1;
          lockout_count_next  = 8'd0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    disp_next.mode       = display_mode_next;
    disp_next.edit_digit = edit_digit_next;
    disp_next.sec        = seconds_value_next;
    disp_next.min        = minutes_value_next;
    disp_next.hr         = hours_value_next;
  end

  csdc_seg_encode u_seg (
    .disp (disp_next),
    .seg  (seg_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_ticks <= csdc_pkg::LOCKOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      lockout_ticks <= cfg_data;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= s_tuser;
      in_sec  <= s_tdata[7:0];
      in_min  <= s_tdata[15:8];
      in_hr   <= s_tdata[23:16];
    end
  end

  // panel state
  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode   <= csdc_pkg::MODE_SEC;
      edit_digit     <= csdc_pkg::DIGIT_NONE;
      seconds_value  <= 8'd0;
      minutes_value  <= 8'd0;
      hours_value    <= 8'd0;
      lockout_active <= 1'b0;
      lockout_count  <= 8'd0;
    end else if (advance) begin
      display_mode   <= display_mode_next;
      edit_digit     <= edit_digit_next;
      seconds_value  <= seconds_value_next;
      minutes_value  <= minutes_value_next;
      hours_value    <= hours_value_next;
      lockout_active <= lockout_active_next;
      lockout_count  <= lockout_count_next;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_seg  <= seg_next;
      out_wv   <= wv_next;
      out_wreg <= wreg_next;
      out_wval <= wval_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_wval, out_wreg, out_seg[3], out_seg[2], out_seg[1], out_seg[0]};
  assign m_tuser  = out_wv;

  `CSDC_ASSERT_NOW(a_write_reg_known, out_valid && out_wv,
                   out_wreg == csdc_pkg::REG_MIN || out_wreg == csdc_pkg::REG_HR)
  `CSDC_ASSERT_NOW(a_count_only_locked, lockout_count != 8'd0, lockout_active)
  `CSDC_ASSERT_NOW(a_mode_range, 1'b1,
                   display_mode >= csdc_pkg::MODE_SEC && display_mode <= csdc_pkg::MODE_WORDC)
  `CSDC_ASSERT_NOW(a_digit_only_time, edit_digit != csdc_pkg::DIGIT_NONE,
                   display_mode == csdc_pkg::MODE_TIME && edit_digit <= csdc_pkg::DIGIT_HR_HI)
  `CSDC_ASSERT_NEXT(a_press_locks, advance && !lockout_active &&
                    (in_kind == csdc_pkg::KIND_NEXT || in_kind == csdc_pkg::KIND_EDIT),
                    lockout_active && lockout_count == 8'd0)

endmodule

// File: rtl/csdc_seg_encode.sv
// seven-segment pattern selection for the four display positions
// depends on csdc_pkg
module csdc_seg_encode (
  input  csdc_pkg::disp_t   disp,
  output logic [3:0][7:0]   seg
);

  always_comb begin
    case (disp.mode)
      csdc_pkg::MODE_SEC: begin
        seg[0] = csdc_pkg::glyph(disp.sec[3:0]);
        seg[1] = csdc_pkg::glyph(disp.sec[7:4]);
        seg[2] = csdc_pkg::SEG_DASH;
        seg[3] = csdc_pkg::SEG_DASH;
      end
      csdc_pkg::MODE_TIME: begin
        seg[0] = csdc_pkg::glyph(disp.min[3:0]);
        seg[1] = csdc_pkg::glyph(disp.min[7:4]);
        seg[2] = csdc_pkg::glyph(disp.hr[3:0]);
        seg[3] = csdc_pkg::glyph(disp.hr[7:4]);
        // decimal point on the digit being edited
        for (int i = 0; i < 4; i++) begin
          if (disp.edit_digit == 3'(i + 1)) seg[i] = seg[i] & csdc_pkg::SEG_DP_MASK;
        end
      end
      csdc_pkg::MODE_WORDA: begin
        seg[0] = csdc_pkg::SEG_CHR_X;
        seg[1] = csdc_pkg::SEG_CHR_E;
        seg[2] = csdc_pkg::SEG_CHR_L;
        seg[3] = csdc_pkg::SEG_CHR_A;
      end
      csdc_pkg::MODE_WORDC: begin
        seg[0] = csdc_pkg::SEG_CHR_C;
        seg[1] = csdc_pkg::SEG_ZERO;
        seg[2] = csdc_pkg::SEG_CHR_L;
        seg[3] = csdc_pkg::SEG_CHR_C;
      end
      default: begin
        seg[0] = csdc_pkg::SEG_DASH;
        seg[1] = csdc_pkg::SEG_DASH;
        seg[2] = csdc_pkg::SEG_DASH;
        seg[3] = csdc_pkg::SEG_DASH;
      end
    endcase
  end

endmodule

// File: tb/tb_clock_set_display_controller_core.sv
// self-checking testbench for clock_set_display_controller_core: stream driver, monitor,
// in-bench panel predictor and lockout register phases; needs csdc_pkg and the core rtl
module tb_clock_set_display_controller_core;
  import csdc_pkg::*;

  localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;
  localparam logic [79:0] DIGIT_SEGS = {8'h09, 8'h01, 8'h1F, 8'h41, 8'h49,
                                        8'h99, 8'h0D, 8'h25, 8'h9F, SEG_ZERO};
  localparam int LONG_HOLD_AT = 100;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int QUIET_LIMIT = 1000;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hr;
  } panel_event_t;

  typedef struct packed {
    logic [3:0][7:0] seg;
    logic            wr_valid;
    logic [2:0]      wr_reg;
    logic [7:0]      wr_value;
  } panel_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;     // seconds_byte, minutes_byte, hours_byte
  logic [2:0]  s_tuser = '0;     // kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;          // seg_pos0..seg_pos3, write_reg, write_value, zero pad
  logic [0:0]  m_tuser;          // write_valid

  clock_set_display_controller_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  panel_event_t event_queue[$];
  panel_word_t  panel_due[$];
  panel_event_t cur_event;

  logic [2:0] p_mode = MODE_SEC;
  logic [2:0] p_digit = DIGIT_NONE;
  logic [7:0] p_sec = '0;
  logic [7:0] p_min = '0;
  logic [7:0] p_hr = '0;
  logic       p_locked = 1'b0;
  logic [7:0] p_lock_count = '0;
  logic [7:0] p_lock_ticks = LOCKOUT_RESET;

  int errors = 0;
  int results = 0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_wait = 0;
  int recv_calm = 0;
  int quiet = 0;

  function automatic logic [7:0] seg_for(input logic [3:0] nib);
    return (nib <= 4'd9) ? DIGIT_SEGS[nib*8 +: 8] : SEG_DASH;
  endfunction

  function automatic logic [7:0] bumped_digit(input logic [2:0] d);
    logic [7:0] r;
    case (d)
      DIGIT_MIN_LO: r = (p_min[3:0] < 4'd9) ? p_min + 8'h01 : {p_min[7:4], 4'h0};
      DIGIT_MIN_HI: r = (p_min[7:4] < 4'd5) ? p_min + 8'h10 : {4'h0, p_min[3:0]};
      DIGIT_HR_LO: begin
        if (p_hr[3:0] < 4'd3) r = p_hr + 8'h01;
        else if (p_hr[7:4] == 4'd2) r = {p_hr[7:4], 4'h0};
        else if (p_hr[3:0] < 4'd9) r = p_hr + 8'h01;
        else r = {p_hr[7:4], 4'h0};
      end
      default: begin
        if (p_hr[7:4] < 4'd1) r = p_hr + 8'h10;
        else if (p_hr[3:0] > 4'd3) r = {4'h0, p_hr[3:0]};
        else if (p_hr[7:4] < 4'd2) r = p_hr + 8'h10;
        else r = {4'h0, p_hr[3:0]};
      end
    endcase
    return r;
  endfunction

  task automatic advance_panel(input panel_event_t ev);
    panel_word_t w;
    w = '0;
    case (ev.kind)
      KIND_TICK: begin
        if (p_locked) begin
          p_lock_count = p_lock_count + 8'd1;
          if (p_lock_count == p_lock_ticks) begin
            p_lock_count = '0;
            p_locked = 1'b0;
          end
        end
      end
      KIND_SEC: p_sec = ev.sec;
      KIND_MIN_HR: begin
        p_min = ev.min;
        p_hr = ev.hr;
      end
      KIND_NEXT, KIND_EDIT: begin
        if (!p_locked) begin
          if (ev.kind == KIND_NEXT) begin
            if (p_digit == DIGIT_NONE) begin
              p_mode = (p_mode >= MODE_SEC && p_mode < MODE_WORDC) ? p_mode + 3'd1 : MODE_SEC;
            end else if (p_mode == MODE_TIME && p_digit <= DIGIT_HR_HI) begin
              w.wr_valid = 1'b1;
              w.wr_reg = (p_digit <= DIGIT_MIN_HI) ? REG_MIN : REG_HR;
              w.wr_value = bumped_digit(p_digit);
            end
          end else if (p_mode == MODE_TIME) begin
            p_digit = (p_digit >= DIGIT_HR_HI) ? DIGIT_NONE : p_digit + 3'd1;
          end
          p_locked = 1'b1;
          p_lock_count = '0;
        end
      end
      default: ;
    endcase
    case (p_mode)
      MODE_SEC: begin
        w.seg[0] = seg_for(p_sec[3:0]);
        w.seg[1] = seg_for(p_sec[7:4]);
        w.seg[2] = SEG_DASH;
        w.seg[3] = SEG_DASH;
      end
      MODE_TIME: begin
        w.seg[0] = seg_for(p_min[3:0]);
        w.seg[1] = seg_for(p_min[7:4]);
        w.seg[2] = seg_for(p_hr[3:0]);
        w.seg[3] = seg_for(p_hr[7:4]);
        if (p_digit >= DIGIT_MIN_LO && p_digit <= DIGIT_HR_HI)
          w.seg[p_digit - 3'd1] = w.seg[p_digit - 3'd1] & SEG_DP_MASK;
      end
      MODE_WORDA: w.seg = {SEG_CHR_A, SEG_CHR_L, SEG_CHR_E, SEG_CHR_X};
      MODE_WORDC: w.seg = {SEG_CHR_C, SEG_CHR_L, SEG_ZERO, SEG_CHR_C};
      default: w.seg = {4{SEG_DASH}};
    endcase
    panel_due.push_back(w);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < PRINT_LIMIT)
      $display("mismatch %s: got %0h expected %0h at result %0d", what, got, want, results);
    errors++;
  endtask

  task automatic check_word();
    panel_word_t want;
    if (panel_due.size() == 0) begin
      report_mismatch("word with none due", m_tdata[31:0], 32'd0);
    end else begin
      want = panel_due.pop_front();
      if (m_tdata[7:0] != want.seg[0])
        report_mismatch("seg_pos0", 32'(m_tdata[7:0]), 32'(want.seg[0]));
      if (m_tdata[15:8] != want.seg[1])
        report_mismatch("seg_pos1", 32'(m_tdata[15:8]), 32'(want.seg[1]));
      if (m_tdata[23:16] != want.seg[2])
        report_mismatch("seg_pos2", 32'(m_tdata[23:16]), 32'(want.seg[2]));
      if (m_tdata[31:24] != want.seg[3])
        report_mismatch("seg_pos3", 32'(m_tdata[31:24]), 32'(want.seg[3]));
      if (m_tuser[0] != want.wr_valid)
        report_mismatch("write_valid", 32'(m_tuser[0]), 32'(want.wr_valid));
      if (m_tdata[34:32] != want.wr_reg)
        report_mismatch("write_reg", 32'(m_tdata[34:32]), 32'(want.wr_reg));
      if (m_tdata[42:35] != want.wr_value)
        report_mismatch("write_value", 32'(m_tdata[42:35]), 32'(want.wr_value));
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) advance_panel(cur_event);
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (event_queue.size() != 0) begin
          cur_event = event_queue.pop_front();
          s_tuser <= cur_event.kind;
          s_tdata <= {cur_event.hr, cur_event.min, cur_event.sec};
          s_tvalid <= 1'b1;
          if (send_calm != 0) send_calm = send_calm - 1;
          else if ($urandom_range(0, 29) == 0) send_calm = 30;
          send_gap = (send_calm != 0) ? 0 : $urandom_range(0, 10);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        check_word();
        results++;
        if (recv_calm != 0) recv_calm = recv_calm - 1;
        else if ($urandom_range(0, 29) == 0) recv_calm = 30;
        if (results == LONG_HOLD_AT) recv_wait = LONG_HOLD_CYCLES;
        else recv_wait = (recv_calm != 0) ? 0 : $urandom_range(0, 10);
        m_tready <= (recv_wait == 0);
      end else if (!m_tready) begin
        if (recv_wait != 0) recv_wait = recv_wait - 1;
        if (recv_wait == 0) m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet = quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_event(input logic [2:0] kind, input logic [7:0] sec,
                            input logic [7:0] min, input logic [7:0] hr);
    event_queue.push_back('{kind: kind, sec: sec, min: min, hr: hr});
  endtask

  task automatic push_press(input logic [2:0] kind);
    push_event(kind, 8'h00, 8'h00, 8'h00);
    push_event(KIND_TICK, 8'h00, 8'h00, 8'h00);
  endtask

  function automatic logic [7:0] rand_bcd(input int tens_max, input int units_max);
    logic [3:0] tens;
    logic [3:0] units;
    if ($urandom_range(0, 9) < 3) return 8'($urandom);
    tens = 4'($urandom_range(0, tens_max));
    units = 4'($urandom_range(0, units_max));
    return {tens, units};
  endfunction

  function automatic logic [7:0] rand_hours();
    logic [3:0] tens;
    logic [3:0] units;
    if ($urandom_range(0, 9) < 3) return 8'($urandom);
    tens = 4'($urandom_range(0, 2));
    units = (tens == 4'd2) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 9));
    return {tens, units};
  endfunction

  task automatic push_noise();
    case ($urandom_range(0, 2))
      0: push_event(KIND_SEC, rand_bcd(5, 9), 8'($urandom), 8'($urandom));
      1: push_event(KIND_MIN_HR, 8'($urandom), rand_bcd(5, 9), rand_hours());
      default: push_event($urandom_range(0, 1) ? KIND_NEXT : KIND_EDIT,
                          8'($urandom), 8'($urandom), 8'($urandom));
    endcase
  endtask

  // press, then about one lockout span of ticks with readings and ignored presses mixed in
  task automatic gen_mix(input int count, input int span);
    int made;
    int ticks;
    made = 0;
    while (made < count) begin
      push_event($urandom_range(0, 1) ? KIND_NEXT : KIND_EDIT,
                 8'($urandom), 8'($urandom), 8'($urandom));
      made++;
      ticks = span - 1 + $urandom_range(0, 2);
      for (int t = 0; t < ticks; t++) begin
        if ($urandom_range(0, 9) == 0) begin
          push_noise();
          made++;
        end
        push_event(KIND_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
        made++;
      end
      if ($urandom_range(0, 19) == 0)
        push_event(3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST)),
                   8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (event_queue.size() != 0 || s_tvalid || panel_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_lockout(input logic [7:0] ticks);
    cfg_data <= ticks;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    p_lock_ticks = ticks;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    gen_mix(20, 128);
    wait_drained();

    write_lockout(8'd1);
    push_event(KIND_SEC, 8'hFF, 8'h00, 8'h00);
    push_event(KIND_SEC, 8'h59, 8'h00, 8'h00);
    push_event(KIND_EDIT, 8'h00, 8'h00, 8'h00);
    push_press(KIND_NEXT);
    push_press(KIND_NEXT);
    push_event(KIND_MIN_HR, 8'h00, 8'h59, 8'h23);
    push_press(KIND_EDIT);
    push_press(KIND_NEXT);
    push_press(KIND_EDIT);
    push_press(KIND_NEXT);
    push_press(KIND_EDIT);
    push_press(KIND_NEXT);
    push_press(KIND_EDIT);
    push_press(KIND_NEXT);
    push_event(KIND_MIN_HR, 8'h00, 8'h00, 8'h14);
    push_press(KIND_NEXT);
    push_press(KIND_EDIT);
    push_press(KIND_NEXT);
    push_press(KIND_NEXT);
    push_event(KIND_UNUSED_LAST, 8'hFF, 8'hFF, 8'hFF);
    push_press(KIND_NEXT);
    wait_drained();

    write_lockout(8'd0);
    gen_mix(250, 256);
    wait_drained();

    write_lockout(8'd2);
    gen_mix(30, 2);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      write_lockout(8'($urandom_range(1, 6)));
      gen_mix(15, int'(p_lock_ticks));
      wait_drained();
    end

    write_lockout(8'd1);
    gen_mix(20, 1);
    wait_drained();
    repeat (8) @(posedge clk);

    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: clock_set_display_controller_core.f
+incdir+rtl
rtl/csdc_pkg.sv
rtl/csdc_seg_encode.sv
rtl/clock_set_display_controller_core.sv
tb/tb_clock_set_display_controller_core.sv
